>>> rtl/icmp_rtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP echo-reply RTT monitor package
// Shared constants, register indexes and the item, record and status types.
// ----------------------------------------------------------------------------
package icmp_rtt_pkg;

  localparam int MAX_FRAME_BYTES = 1536;
  localparam int QUEUE_DEPTH     = 4;

  localparam int POS_W = 11;
  localparam logic [POS_W-1:0] POS_MAX = 11'd2047;

  // Frame byte offsets
  localparam logic [POS_W-1:0] OFS_TYPE_HI = 11'd12;
  localparam logic [POS_W-1:0] OFS_TYPE_LO = 11'd13;
  localparam logic [POS_W-1:0] OFS_VER_IHL = 11'd14;
  localparam logic [POS_W-1:0] OFS_PROTO   = 11'd23;
  localparam logic [POS_W-1:0] ETH_HDR_LEN = 11'd14;

  localparam logic [7:0] ETH_TYPE_HI     = 8'h08;
  localparam logic [7:0] ETH_TYPE_LO     = 8'h00;
  localparam logic [3:0] IP_VERSION      = 4'd4;
  localparam logic [3:0] IHL_MIN         = 4'd5;
  localparam logic [7:0] PROTO_ICMP      = 8'h01;
  localparam logic [7:0] ICMP_ECHO_REPLY = 8'h00;
  localparam logic [5:0] MIN_IP_HDR      = 6'd20;
  localparam logic [11:0] ICMP_NEEDED    = 12'd16;

  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

  localparam logic [31:0] RESET_SLOW_THRESHOLD = 32'd10000;
  localparam logic [11:0] RESET_MAX_AGE        = 12'd3600;

  typedef enum logic {
    REG_SLOW_THRESHOLD = 1'b0,
    REG_MAX_AGE        = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               last_byte;
    logic signed [31:0] now_sec;
    logic [19:0]        now_usec;
  } in_item_t;

  typedef struct packed {
    logic        matched;
    logic [15:0] seq_number;
    logic [31:0] rtt_us;
    logic [31:0] reply_count;
    logic [31:0] slow_count;
    logic [31:0] max_rtt_us;
    logic [15:0] max_rtt_seq;
    logic [15:0] slow_seq;
    logic [31:0] slow_rtt_us;
  } out_item_t;

  // One finished frame, handed from the parser to the RTT back end
  typedef struct packed {
    logic        ok;
    logic [15:0] seq;
    logic [31:0] sent_sec;
    logic [31:0] sent_usec;
    logic [31:0] now_sec;
    logic [19:0] now_usec;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

>>> rtl/icmp_rtt_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP RTT frame parser
// Checks the Ethernet, IPv4 and ICMP headers byte by byte, captures sequence
// and send time, and pushes one record per frame into the queue.
// ----------------------------------------------------------------------------
module icmp_rtt_parse (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  icmp_rtt_pkg::in_item_t  in_data,
  output logic                    in_stall,
  input  icmp_rtt_pkg::fifo_stat_t q_stat,
  output logic                    push,
  output icmp_rtt_pkg::frame_rec_t push_rec
);
  import icmp_rtt_pkg::*;

  logic [POS_W-1:0] byte_pos;
  logic [5:0]       hdr_bytes;
  logic             frame_ok;
  logic [15:0]      cap_seq;
  logic [31:0]      cap_sec;
  logic [31:0]      cap_usec;

  logic             take;
  logic [7:0]       b;
  logic [5:0]       hdr_eff;
  logic             ok_upd;
  logic [15:0]      seq_upd;
  logic [31:0]      sec_upd;
  logic [31:0]      usec_upd;
  logic [POS_W-1:0] icmp_start;
  logic [POS_W-1:0] rel;
  logic [11:0]      rx_len;
  logic [11:0]      len_needed;
  logic             end_ok;

  assign in_stall = q_stat.full;
  assign take     = in_valid && !q_stat.full;
  assign b        = in_data.data_byte;

  always_comb begin
    hdr_eff  = hdr_bytes;
    ok_upd   = frame_ok;
    seq_upd  = cap_seq;
    sec_upd  = cap_sec;
    usec_upd = cap_usec;
    if (byte_pos == OFS_TYPE_HI && b != ETH_TYPE_HI) ok_upd = 1'b0;
    if (byte_pos == OFS_TYPE_LO && b != ETH_TYPE_LO) ok_upd = 1'b0;
    if (byte_pos == OFS_VER_IHL) begin
      if (b[7:4] != IP_VERSION || b[3:0] < IHL_MIN) ok_upd = 1'b0;
      hdr_eff = {b[3:0], 2'b00};
    end
    if (byte_pos == OFS_PROTO && b != PROTO_ICMP) ok_upd = 1'b0;

    icmp_start = ETH_HDR_LEN + {5'b0, hdr_eff};
    rel        = byte_pos - icmp_start;
    if (hdr_eff >= MIN_IP_HDR && byte_pos >= icmp_start && rel[POS_W-1:4] == '0) begin
      case (rel[3:0])
        4'd0, 4'd1: if (b != ICMP_ECHO_REPLY) ok_upd = 1'b0;
        4'd6:  seq_upd[7:0]    = b;
        4'd7:  seq_upd[15:8]   = b;
        4'd8:  sec_upd[7:0]    = b;
        4'd9:  sec_upd[15:8]   = b;
        4'd10: sec_upd[23:16]  = b;
        4'd11: sec_upd[31:24]  = b;
        4'd12: usec_upd[7:0]   = b;
        4'd13: usec_upd[15:8]  = b;
        4'd14: usec_upd[23:16] = b;
        4'd15: usec_upd[31:24] = b;
        default: ;
      endcase
    end

    rx_len     = {1'b0, byte_pos} + 12'd1;
    len_needed = {1'b0, icmp_start} + ICMP_NEEDED;
    end_ok     = ok_upd && hdr_eff >= MIN_IP_HDR && rx_len >= len_needed &&
                 rx_len <= 12'(MAX_FRAME_BYTES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos  <= '0;
      hdr_bytes <= '0;
      frame_ok  <= 1'b1;
    end else if (take) begin
      if (in_data.last_byte) begin
        byte_pos  <= '0;
        hdr_bytes <= '0;
        frame_ok  <= 1'b1;
      end else begin
        byte_pos  <= (byte_pos == POS_MAX) ? byte_pos : byte_pos + 1'b1;
        hdr_bytes <= hdr_eff;
        frame_ok  <= ok_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_seq  <= '0;
      cap_sec  <= '0;
      cap_usec <= '0;
    end else if (take) begin
      cap_seq  <= seq_upd;
      cap_sec  <= sec_upd;
      cap_usec <= usec_upd;
    end
  end

  assign push = take && in_data.last_byte;

  always_comb begin
    push_rec.ok        = end_ok;
    push_rec.seq       = seq_upd;
    push_rec.sent_sec  = sec_upd;
    push_rec.sent_usec = usec_upd;
    push_rec.now_sec   = in_data.now_sec;
    push_rec.now_usec  = in_data.now_usec;
  end

endmodule

>>> rtl/icmp_rtt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP RTT frame record queue
// Small register queue between the parser and the RTT back end.
// ----------------------------------------------------------------------------
module icmp_rtt_fifo #(
  parameter int DEPTH = icmp_rtt_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  icmp_rtt_pkg::frame_rec_t push_rec,
  input  logic                     pop,
  output icmp_rtt_pkg::frame_rec_t pop_rec,
  output icmp_rtt_pkg::fifo_stat_t stat
);
  import icmp_rtt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_rec_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_rec    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_rec;
  end

endmodule

>>> rtl/icmp_rtt_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP RTT calculation and statistics
// Four-stage back end: time differences, borrow and age check, RTT multiply,
// then statistics update into the output register.
// ----------------------------------------------------------------------------
module icmp_rtt_calc (
  input  logic                     clk,
  input  logic                     rst,
  input  icmp_rtt_pkg::fifo_stat_t q_stat,
  input  icmp_rtt_pkg::frame_rec_t pop_rec,
  output logic                     pop,
  input  logic [31:0]              slow_threshold,
  input  logic [11:0]              max_age,
  output logic                     out_valid,
  input  logic                     out_stall,
  output icmp_rtt_pkg::out_item_t  out_data
);
  import icmp_rtt_pkg::*;

  logic        back_en;

  // stage 1
  logic        s1_valid;
  logic        s1_ok;
  logic [15:0] s1_seq;
  logic [32:0] s1_sec_d;
  logic [33:0] s1_usec_d;
  // stage 2
  logic        s2_valid;
  logic        s2_ok;
  logic [15:0] s2_seq;
  logic [11:0] s2_sec;
  logic [31:0] s2_usec;
  // stage 3
  logic        s3_valid;
  logic        s3_ok;
  logic [15:0] s3_seq;
  logic [31:0] s3_rtt;

  logic [32:0] sec_adj;
  logic [33:0] usec_adj;
  logic        age_ok;
  logic [31:0] rtt_prod;
  logic        final_ok;

  logic [31:0] reply_cnt;
  logic [31:0] slow_cnt;
  logic [31:0] max_rtt;
  logic [15:0] max_seq;
  logic [15:0] slow_seq;
  logic [31:0] slow_rtt;
  logic [31:0] reply_cnt_next;
  logic [31:0] slow_cnt_next;
  logic [31:0] max_rtt_next;
  logic [15:0] max_seq_next;
  logic [15:0] slow_seq_next;
  logic [31:0] slow_rtt_next;

  // advance the whole back end unless the result register is held
  assign back_en = !out_valid || !out_stall;
  assign pop     = back_en && !q_stat.empty;

  // borrow one second when the microsecond difference goes negative
  always_comb begin
    usec_adj = s1_usec_d[33] ? s1_usec_d + 34'(USEC_PER_SEC) : s1_usec_d;
    sec_adj  = s1_sec_d - {32'b0, s1_usec_d[33]};
    age_ok   = !sec_adj[32] && (sec_adj[31:0] <= {20'b0, max_age});
  end

  assign rtt_prod = s2_sec * USEC_PER_SEC;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (back_en) begin
      s1_valid <= !q_stat.empty;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      s1_ok     <= pop_rec.ok;
      s1_seq    <= pop_rec.seq;
      s1_sec_d  <= {pop_rec.now_sec[31], pop_rec.now_sec} -
                   {pop_rec.sent_sec[31], pop_rec.sent_sec};
      s1_usec_d <= {14'b0, pop_rec.now_usec} -
                   {{2{pop_rec.sent_usec[31]}}, pop_rec.sent_usec};
      s2_ok     <= s1_ok && age_ok;
      s2_seq    <= s1_seq;
      s2_sec    <= sec_adj[11:0];
      s2_usec   <= usec_adj[31:0];
      s3_ok     <= s2_ok;
      s3_seq    <= s2_seq;
      s3_rtt    <= rtt_prod + s2_usec;
    end
  end

  assign final_ok = s3_ok && (s3_rtt != '0);

  always_comb begin
    reply_cnt_next = reply_cnt;
    slow_cnt_next  = slow_cnt;
    max_rtt_next   = max_rtt;
    max_seq_next   = max_seq;
    slow_seq_next  = slow_seq;
    slow_rtt_next  = slow_rtt;
    if (final_ok) begin
      reply_cnt_next = reply_cnt + 1'b1;
      if (s3_rtt > max_rtt) begin
        max_rtt_next = s3_rtt;
        max_seq_next = s3_seq;
      end
      if (s3_rtt >= slow_threshold) begin
        slow_cnt_next = slow_cnt + 1'b1;
        slow_seq_next = s3_seq;
        slow_rtt_next = s3_rtt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_cnt <= '0;
      slow_cnt  <= '0;
      max_rtt   <= '0;
      max_seq   <= '0;
      slow_seq  <= '0;
      slow_rtt  <= '0;
      out_valid <= 1'b0;
    end else if (back_en) begin
      out_valid <= s3_valid;
      if (s3_valid) begin
        reply_cnt <= reply_cnt_next;
        slow_cnt  <= slow_cnt_next;
        max_rtt   <= max_rtt_next;
        max_seq   <= max_seq_next;
        slow_seq  <= slow_seq_next;
        slow_rtt  <= slow_rtt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (back_en && s3_valid) begin
      out_data.matched     <= final_ok;
      out_data.seq_number  <= final_ok ? s3_seq : 16'd0;
      out_data.rtt_us      <= final_ok ? s3_rtt : 32'd0;
      out_data.reply_count <= reply_cnt_next;
      out_data.slow_count  <= slow_cnt_next;
      out_data.max_rtt_us  <= max_rtt_next;
      out_data.max_rtt_seq <= max_seq_next;
      out_data.slow_seq    <= slow_seq_next;
      out_data.slow_rtt_us <= slow_rtt_next;
    end
  end

`ifndef SYNTH
  a_match_nonzero_rtt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.matched |-> out_data.rtt_us != 32'd0)
    else $error("accepted reply with zero RTT");

  a_max_covers_rtt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.matched |-> out_data.max_rtt_us >= out_data.rtt_us)
    else $error("maximum RTT below current RTT");

  a_reject_zeroed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.matched |-> out_data.seq_number == 16'd0 &&
                                      out_data.rtt_us == 32'd0)
    else $error("rejected frame carries sequence or RTT");

  a_stats_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(reply_cnt) && $stable(slow_cnt))
    else $error("statistics moved while result held");
`endif

endmodule

>>> rtl/icmp_echo_reply_rtt_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP echo-reply round-trip-time monitor
// Parses received frame bytes, measures the RTT of ICMP echo replies and keeps
// reply statistics; two configuration registers on an APB-style port.
// ----------------------------------------------------------------------------
//  port group   dir  handshake              payload
//  in_*         in   in_valid / in_stall    in_item_t, one frame byte
//  out_*        out  out_valid / out_stall  out_item_t, one per frame
//  p*           in   psel/penable/pready    threshold at 0x0, max age at 0x4
//
// One frame byte is taken every cycle while in_stall is low; a result passes
// the four back-end stages (difference, borrow, multiply, statistics) after the
// last byte. Synchronous reset clears parser, queue, statistics and restores
// the register reset values. A held result stalls only the back end; a queue
// of QUEUE_DEPTH frame records absorbs it, and in_stall rises when it is full.
// ----------------------------------------------------------------------------
module icmp_echo_reply_rtt_monitor #(
  parameter int QUEUE_DEPTH = icmp_rtt_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  icmp_rtt_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output icmp_rtt_pkg::out_item_t out_data,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import icmp_rtt_pkg::*;

  logic [31:0] slow_threshold;
  logic [11:0] max_age;
  reg_idx_t    reg_sel;

  fifo_stat_t  q_stat;
  logic        push;
  frame_rec_t  push_rec;
  logic        pop;
  frame_rec_t  pop_rec;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_threshold <= RESET_SLOW_THRESHOLD;
      max_age        <= RESET_MAX_AGE;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_SLOW_THRESHOLD: slow_threshold <= pwdata;
        REG_MAX_AGE:        max_age        <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SLOW_THRESHOLD: prdata = slow_threshold;
      REG_MAX_AGE:        prdata = {20'b0, max_age};
      default:            prdata = '0;
    endcase
  end

  icmp_rtt_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  icmp_rtt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .stat     (q_stat)
  );

  icmp_rtt_calc u_calc (
    .clk            (clk),
    .rst            (rst),
    .q_stat         (q_stat),
    .pop_rec        (pop_rec),
    .pop            (pop),
    .slow_threshold (slow_threshold),
    .max_age        (max_age),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule
